// File: hw/rtl/sphere_quad_vertex_gen_macros.svh
// Assertion macros for the RTL of the sphere vertex generator.
`ifndef SPHERE_QUAD_VERTEX_GEN_MACROS_SVH
`define SPHERE_QUAD_VERTEX_GEN_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SQVG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define SQVG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/sqvg_pkg.sv
`default_nettype none
package sqvg_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int TRIG_STAGES = 16;

    localparam int IDX_W = 11;
    localparam int CNT_W = 11;
    localparam int RAD_W = 15;
    localparam int NUM_W = IDX_W + ANGLE_BITS;
    localparam int XY_W = 34;
    localparam int Z_W = 33;
    localparam int STG_W = 5;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_STACKS = 2'd1;
    localparam logic [1:0] REG_SLICES = 2'd2;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST = 2'd3;

    function automatic logic [30:0] atan_turn(input logic [STG_W-1:0] k);
        logic [30:0] v;
        case (k)
            5'd0:    v = 31'd536870912;
            5'd1:    v = 31'd316933405;
            5'd2:    v = 31'd167458907;
            5'd3:    v = 31'd85004756;
            5'd4:    v = 31'd42667331;
            5'd5:    v = 31'd21354465;
            5'd6:    v = 31'd10679838;
            5'd7:    v = 31'd5340245;
            5'd8:    v = 31'd2670163;
            5'd9:    v = 31'd1335086;
            5'd10:   v = 31'd667544;
            5'd11:   v = 31'd333772;
            5'd12:   v = 31'd166886;
            5'd13:   v = 31'd83443;
            5'd14:   v = 31'd41721;
            5'd15:   v = 31'd20860;
            5'd16:   v = 31'd10430;
            5'd17:   v = 31'd5215;
            5'd18:   v = 31'd2607;
            5'd19:   v = 31'd1303;
            5'd20:   v = 31'd651;
            5'd21:   v = 31'd325;
            5'd22:   v = 31'd162;
            5'd23:   v = 31'd81;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
        logic signed [15:0] r;
        if (v > 50'sd32767)
        begin
            r = 16'sd32767;
        end
        else if (v < -50'sd32768)
        begin
            r = -16'sd32768;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] round_q15(input logic signed [XY_W-1:0] v);
        logic signed [49:0] t;
        t = (50'(v) + 50'sd16384) >>> 15;
        return sat16(t);
    endfunction

    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        return sat16(-50'(v));
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sqvg_ifs.sv
`default_nettype none
interface sqvg_quad_if;
    logic       valid;
    logic       ready;
    logic [9:0] stack_index;
    logic [9:0] slice_index;
    modport source (output valid, output stack_index, output slice_index, input ready);
    modport sink (input valid, input stack_index, input slice_index, output ready);
endinterface

interface sqvg_vertex_if;
    logic               valid;
    logic               ready;
    logic [1:0]         corner;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               last_corner;
    modport source (output valid, output corner, output pos_x, output pos_y,
                    output pos_z, output last_corner, input ready);
    modport sink (input valid, input corner, input pos_x, input pos_y,
                  input pos_z, input last_corner, output ready);
endinterface

interface sqvg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [14:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sqvg_div_cell.sv
`default_nettype none
module sqvg_div_cell
    import sqvg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [CNT_W-1:0]      divisor,
    input  wire logic [NUM_W-1:0]      num_in,
    input  wire logic [CNT_W-1:0]      rem_in,
    input  wire logic [ANGLE_BITS-1:0] quo_in,
    output logic [NUM_W-1:0]           num_out,
    output logic [CNT_W-1:0]           rem_out,
    output logic [ANGLE_BITS-1:0]      quo_out
);

    logic [CNT_W:0]   trial;
    logic             ge;
    logic [CNT_W:0]   diff;
    logic [CNT_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_in, num_in[NUM_W-1]};
        ge = trial >= {1'b0, divisor};
        diff = trial - {1'b0, divisor};
        rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_out <= {num_in[NUM_W-2:0], 1'b0};
            rem_out <= rem_next;
            quo_out <= {quo_in[ANGLE_BITS-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/sqvg_cordic_cell.sv
`default_nettype none
module sqvg_cordic_cell
    import sqvg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [STG_W-1:0]       stage,
    input  wire logic signed [XY_W-1:0] x_in,
    input  wire logic signed [XY_W-1:0] y_in,
    input  wire logic signed [Z_W-1:0]  z_in,
    output logic signed [XY_W-1:0]      x_out,
    output logic signed [XY_W-1:0]      y_out,
    output logic signed [Z_W-1:0]       z_out
);

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  at;

    always_comb
    begin
        xs = x_in >>> stage;
        ys = y_in >>> stage;
        at = $signed({2'b00, atan_turn(stage)});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!z_in[Z_W-1])
            begin
                x_out <= x_in - ys;
                y_out <= y_in + xs;
                z_out <= z_in - at;
            end
            else
            begin
                x_out <= x_in + ys;
                y_out <= y_in - xs;
                z_out <= z_in + at;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/sphere_quad_vertex_gen.sv
// Sphere quad vertex generator. Each beat on quad names a latitude band and a
// longitude segment; four beats leave on vertex, corners (i,j), (i+1,j),
// (i+1,j+1), (i,j+1), the last one flagged by last_corner. A corner
// sequencer feeds one corner per cycle while vertex is not stalled into a
// pipeline of 27 restoring divider cells, 16 CORDIC cells and four rounding
// and multiply stages; a new quad is taken as the last corner of the
// previous one enters the pipeline. A stalled vertex beat stalls the whole
// pipeline. The user must write registers through cfg only while the block
// is idle; the block does not enforce this. cfg is always ready.
`default_nettype none
module sphere_quad_vertex_gen
    import sqvg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    sqvg_quad_if.sink     quad,
    sqvg_vertex_if.source vertex,
    sqvg_cfg_if.sink      cfg
);

`include "sphere_quad_vertex_gen_macros.svh"

    localparam int CRD0 = 1 + NUM_W;
    localparam int POST = CRD0 + TRIG_STAGES;
    localparam int NSTG = POST + 4;

    logic [RAD_W-1:0] radius_reg;
    logic [CNT_W-1:0] stacks_reg;
    logic [CNT_W-1:0] slices_reg;
    logic [CNT_W-1:0] st_div;
    logic [CNT_W-1:0] sl_div;

    logic             busy_reg;
    logic [1:0]       seq_corner_reg;
    logic [9:0]       i_reg;
    logic [9:0]       j_reg;
    logic             adv;
    logic             quad_acc;

    logic [NSTG-1:0]  valid_reg;
    logic [1:0]       corner_reg [NSTG];

    logic [NUM_W-1:0]      num_t [NUM_W+1];
    logic [NUM_W-1:0]      num_p [NUM_W+1];
    logic [CNT_W-1:0]      rem_t [NUM_W+1];
    logic [CNT_W-1:0]      rem_p [NUM_W+1];
    logic [ANGLE_BITS-1:0] quo_t [NUM_W+1];
    logic [ANGLE_BITS-1:0] quo_p [NUM_W+1];

    logic signed [XY_W-1:0] xt [TRIG_STAGES+1];
    logic signed [XY_W-1:0] yt [TRIG_STAGES+1];
    logic signed [Z_W-1:0]  zt [TRIG_STAGES+1];
    logic signed [XY_W-1:0] xp [TRIG_STAGES+1];
    logic signed [XY_W-1:0] yp [TRIG_STAGES+1];
    logic signed [Z_W-1:0]  zp [TRIG_STAGES+1];
    logic [1:0]             qt_reg [TRIG_STAGES];
    logic [1:0]             qp_reg [TRIG_STAGES];

    logic [IDX_W-1:0]  a_idx;
    logic [IDX_W-1:0]  b_idx;
    logic [NUM_W-1:0]  num_t_next;
    logic [NUM_W-1:0]  num_p_next;

    logic signed [15:0] ct;
    logic signed [15:0] stt;
    logic signed [15:0] cp;
    logic signed [15:0] sp;
    logic signed [15:0] c_t;
    logic signed [15:0] s_t;
    logic signed [15:0] c_p;
    logic signed [15:0] s_p;
    logic signed [15:0] ct_reg;
    logic signed [15:0] st_reg;
    logic signed [15:0] cp_reg;
    logic signed [15:0] sp_reg;
    logic signed [31:0] rs_reg;
    logic signed [31:0] rz_reg;
    logic signed [15:0] cp1_reg;
    logic signed [15:0] sp1_reg;
    logic signed [47:0] px_reg;
    logic signed [47:0] py_reg;
    logic signed [31:0] rz2_reg;
    logic signed [15:0] pos_x_reg;
    logic signed [15:0] pos_y_reg;
    logic signed [15:0] pos_z_reg;
    logic signed [16:0] rad_s;

    assign st_div = (stacks_reg == '0) ? CNT_W'(1) : stacks_reg;
    assign sl_div = (slices_reg == '0) ? CNT_W'(1) : slices_reg;
    assign rad_s = $signed({2'b00, radius_reg});

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_W'(50);
            stacks_reg <= CNT_W'(10);
            slices_reg <= CNT_W'(10);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_RADIUS: radius_reg <= cfg.data[RAD_W-1:0];
                REG_STACKS: stacks_reg <= cfg.data[CNT_W-1:0];
                REG_SLICES: slices_reg <= cfg.data[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    assign adv = !valid_reg[NSTG-1] || vertex.ready;
    assign quad.ready = !busy_reg || (adv && seq_corner_reg == CORNER_LAST);
    assign quad_acc = quad.valid && quad.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            seq_corner_reg <= CORNER_FIRST;
        end
        else if (quad_acc)
        begin
            busy_reg <= 1'b1;
            seq_corner_reg <= CORNER_FIRST;
        end
        else if (adv && busy_reg)
        begin
            seq_corner_reg <= seq_corner_reg + 2'd1;
            if (seq_corner_reg == CORNER_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (quad_acc)
        begin
            i_reg <= quad.stack_index;
            j_reg <= quad.slice_index;
        end
    end

    always_comb
    begin
        a_idx = (seq_corner_reg == 2'd1 || seq_corner_reg == 2'd2)
                ? IDX_W'(i_reg) + IDX_W'(1) : IDX_W'(i_reg);
        b_idx = (seq_corner_reg == 2'd2 || seq_corner_reg == 2'd3)
                ? IDX_W'(j_reg) + IDX_W'(1) : IDX_W'(j_reg);
        num_t_next = (NUM_W'(a_idx) << (ANGLE_BITS - 1)) + NUM_W'(st_div >> 1);
        num_p_next = (NUM_W'(b_idx) << ANGLE_BITS) + NUM_W'(sl_div >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NSTG-2:0], busy_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            corner_reg[0] <= seq_corner_reg;
            for (int s = 1; s < NSTG; s++)
            begin
                corner_reg[s] <= corner_reg[s-1];
            end
            num_t[0] <= num_t_next;
            num_p[0] <= num_p_next;
        end
    end

    assign rem_t[0] = '0;
    assign rem_p[0] = '0;
    assign quo_t[0] = '0;
    assign quo_p[0] = '0;

    for (genvar d = 0; d < NUM_W; d++)
    begin : g_div
        sqvg_div_cell u_div_t (
            .clk     (clk),
            .en      (adv),
            .divisor (st_div),
            .num_in  (num_t[d]),
            .rem_in  (rem_t[d]),
            .quo_in  (quo_t[d]),
            .num_out (num_t[d+1]),
            .rem_out (rem_t[d+1]),
            .quo_out (quo_t[d+1])
        );
        sqvg_div_cell u_div_p (
            .clk     (clk),
            .en      (adv),
            .divisor (sl_div),
            .num_in  (num_p[d]),
            .rem_in  (rem_p[d]),
            .quo_in  (quo_p[d]),
            .num_out (num_p[d+1]),
            .rem_out (rem_p[d+1]),
            .quo_out (quo_p[d+1])
        );
    end

    assign xt[0] = CORDIC_GAIN;
    assign yt[0] = '0;
    assign zt[0] = $signed({3'b000, quo_t[NUM_W][ANGLE_BITS-3:0], (32 - ANGLE_BITS)'(0)});
    assign xp[0] = CORDIC_GAIN;
    assign yp[0] = '0;
    assign zp[0] = $signed({3'b000, quo_p[NUM_W][ANGLE_BITS-3:0], (32 - ANGLE_BITS)'(0)});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qt_reg[0] <= quo_t[NUM_W][ANGLE_BITS-1:ANGLE_BITS-2];
            qp_reg[0] <= quo_p[NUM_W][ANGLE_BITS-1:ANGLE_BITS-2];
            for (int s = 1; s < TRIG_STAGES; s++)
            begin
                qt_reg[s] <= qt_reg[s-1];
                qp_reg[s] <= qp_reg[s-1];
            end
        end
    end

    for (genvar k = 0; k < TRIG_STAGES; k++)
    begin : g_cordic
        sqvg_cordic_cell u_crd_t (
            .clk   (clk),
            .en    (adv),
            .stage (STG_W'(k)),
            .x_in  (xt[k]),
            .y_in  (yt[k]),
            .z_in  (zt[k]),
            .x_out (xt[k+1]),
            .y_out (yt[k+1]),
            .z_out (zt[k+1])
        );
        sqvg_cordic_cell u_crd_p (
            .clk   (clk),
            .en    (adv),
            .stage (STG_W'(k)),
            .x_in  (xp[k]),
            .y_in  (yp[k]),
            .z_in  (zp[k]),
            .x_out (xp[k+1]),
            .y_out (yp[k+1]),
            .z_out (zp[k+1])
        );
    end

    always_comb
    begin
        c_t = round_q15(xt[TRIG_STAGES]);
        s_t = round_q15(yt[TRIG_STAGES]);
        c_p = round_q15(xp[TRIG_STAGES]);
        s_p = round_q15(yp[TRIG_STAGES]);
        case (qt_reg[TRIG_STAGES-1])
            2'd0:    begin ct = c_t;          stt = s_t;          end
            2'd1:    begin ct = neg_sat(s_t); stt = c_t;          end
            2'd2:    begin ct = neg_sat(c_t); stt = neg_sat(s_t); end
            default: begin ct = s_t;          stt = neg_sat(c_t); end
        endcase
        case (qp_reg[TRIG_STAGES-1])
            2'd0:    begin cp = c_p;          sp = s_p;          end
            2'd1:    begin cp = neg_sat(s_p); sp = c_p;          end
            2'd2:    begin cp = neg_sat(c_p); sp = neg_sat(s_p); end
            default: begin cp = s_p;          sp = neg_sat(c_p); end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ct_reg <= ct;
            st_reg <= stt;
            cp_reg <= cp;
            sp_reg <= sp;
            rs_reg <= rad_s * st_reg;
            rz_reg <= rad_s * ct_reg;
            cp1_reg <= cp_reg;
            sp1_reg <= sp_reg;
            px_reg <= rs_reg * cp1_reg;
            py_reg <= rs_reg * sp1_reg;
            rz2_reg <= rz_reg;
            pos_x_reg <= sat16((50'(px_reg) + 50'sd536870912) >>> 30);
            pos_y_reg <= sat16((50'(py_reg) + 50'sd536870912) >>> 30);
            pos_z_reg <= sat16((50'(rz2_reg) + 50'sd16384) >>> 15);
        end
    end

    assign vertex.valid = valid_reg[NSTG-1];
    assign vertex.corner = corner_reg[NSTG-1];
    assign vertex.pos_x = pos_x_reg;
    assign vertex.pos_y = pos_y_reg;
    assign vertex.pos_z = pos_z_reg;
    assign vertex.last_corner = (corner_reg[NSTG-1] == CORNER_LAST);

    `SQVG_ASSERT_NEXT(a_seq_start, quad_acc, busy_reg && seq_corner_reg == CORNER_FIRST)
    `SQVG_ASSERT_NEXT(a_stall_holds, vertex.valid && !vertex.ready, $stable(valid_reg))
    `SQVG_ASSERT_SAME(a_no_accept_busy, busy_reg && seq_corner_reg != CORNER_LAST, !quad.ready)

endmodule
`default_nettype wire
